/* sv/iadsp_pkg.sv */
// Shared types, constants and helpers of the integer ALU with divide, root and power.
package iadsp_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int EXP_BITS   = $clog2(DATA_WIDTH);
   localparam int SQ_STEPS   = DATA_WIDTH / 2;
   localparam int POW_STEPS  = 2 * EXP_BITS;
   localparam int UNIT_DEPTH = DATA_WIDTH;
   localparam int LATENCY    = UNIT_DEPTH + 2;

   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam logic [2:0] MODE_ADD  = 3'd0;
   localparam logic [2:0] MODE_SUB  = 3'd1;
   localparam logic [2:0] MODE_MUL  = 3'd2;
   localparam logic [2:0] MODE_DIV  = 3'd3;
   localparam logic [2:0] MODE_SQRT = 3'd4;
   localparam logic [2:0] MODE_POW  = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_DOMAIN = 2'd1;
   localparam logic [1:0] ST_SAT    = 2'd2;

   typedef struct packed {
      logic [2:0]                   mode;
      logic signed [DATA_WIDTH-1:0] operand_a;
      logic signed [DATA_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result;
      logic [1:0]                   status;
   } rsp_type;

   // magnitude of a two's complement word; the most negative value maps to 2^(W-1)
   function automatic word_type mag(word_type x);
      return x[DATA_WIDTH-1] ? (~x + word_type'(1)) : x;
   endfunction

endpackage

/* sv/iadsp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, signed truncation.
module iadsp_div (
   input  logic              clock,
   input  iadsp_pkg::word_type a,
   input  iadsp_pkg::word_type b,
   output iadsp_pkg::rsp_type  res
);
   import iadsp_pkg::*;

   word_type rem_ff [UNIT_DEPTH];
   word_type rem_in [UNIT_DEPTH];
   word_type num_ff [UNIT_DEPTH];
   word_type num_in [UNIT_DEPTH];
   word_type den_ff [UNIT_DEPTH];
   word_type den_in [UNIT_DEPTH];
   logic     neg_ff [UNIT_DEPTH];
   logic     neg_in [UNIT_DEPTH];
   logic     zero_ff [UNIT_DEPTH];
   logic     zero_in [UNIT_DEPTH];

   function automatic logic [2*DATA_WIDTH-1:0] div_step(word_type rem, word_type num,
                                                        word_type den);
      logic [DATA_WIDTH:0] t;
      logic [DATA_WIDTH:0] diff;
      logic                ge;
      t    = {rem, num[DATA_WIDTH-1]};
      diff = t - {1'b0, den};
      ge   = (t >= {1'b0, den});
      return {(ge ? diff[DATA_WIDTH-1:0] : t[DATA_WIDTH-1:0]), num[DATA_WIDTH-2:0], ge};
   endfunction

   always_comb begin
      {rem_in[0], num_in[0]} = div_step('0, mag(a), mag(b));
      den_in[0]  = mag(b);
      neg_in[0]  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      zero_in[0] = (b == '0);
      for (int k = 1; k < UNIT_DEPTH; k++) begin
         {rem_in[k], num_in[k]} = div_step(rem_ff[k-1], num_ff[k-1], den_ff[k-1]);
         den_in[k]  = den_ff[k-1];
         neg_in[k]  = neg_ff[k-1];
         zero_in[k] = zero_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff[UNIT_DEPTH-1]) begin
         res = {word_type'(0), ST_DOMAIN};
      end else if (neg_ff[UNIT_DEPTH-1]) begin
         res = {word_type'(~num_ff[UNIT_DEPTH-1] + word_type'(1)), ST_OK};
      end else begin
         res = {num_ff[UNIT_DEPTH-1], ST_OK};
      end
   end

endmodule

/* sv/iadsp_sqrt.sv */
// Pipelined digit-by-digit integer square root, two radicand bits per stage.
module iadsp_sqrt (
   input  logic              clock,
   input  iadsp_pkg::word_type a,
   output iadsp_pkg::rsp_type  res
);
   import iadsp_pkg::*;

   word_type x_ff [UNIT_DEPTH];
   word_type x_in [UNIT_DEPTH];
   word_type r_ff [UNIT_DEPTH];
   word_type r_in [UNIT_DEPTH];
   logic     neg_ff [UNIT_DEPTH];
   logic     neg_in [UNIT_DEPTH];

   always_comb begin
      word_type xp;
      word_type rp;
      word_type bitv;
      word_type sum;
      for (int k = 0; k < UNIT_DEPTH; k++) begin
         xp = (k == 0) ? a : x_ff[(k == 0) ? 0 : k-1];
         rp = (k == 0) ? '0 : r_ff[(k == 0) ? 0 : k-1];
         neg_in[k] = (k == 0) ? a[DATA_WIDTH-1] : neg_ff[(k == 0) ? 0 : k-1];
         x_in[k] = xp;
         r_in[k] = rp;
         if (k < SQ_STEPS) begin
            bitv = word_type'(1) << (2 * (SQ_STEPS - 1 - k));
            sum  = rp + bitv;
            if (xp >= sum) begin
               x_in[k] = xp - sum;
               r_in[k] = (rp >> 1) + bitv;
            end else begin
               r_in[k] = rp >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff[UNIT_DEPTH-1]) begin
         res = {word_type'(0), ST_DOMAIN};
      end else begin
         res = {r_ff[UNIT_DEPTH-1], ST_OK};
      end
   end

endmodule

/* sv/iadsp_pow.sv */
// Pipelined square-and-multiply power with exact saturation, one multiply per stage.
module iadsp_pow (
   input  logic              clock,
   input  iadsp_pkg::word_type a,
   input  iadsp_pkg::word_type b,
   output iadsp_pkg::rsp_type  res
);
   import iadsp_pkg::*;

   localparam logic [2*DATA_WIDTH-1:0] LIM_POS = (2*DATA_WIDTH)'(1) << (DATA_WIDTH-1);

   word_type            acc_ff [UNIT_DEPTH];
   word_type            acc_in [UNIT_DEPTH];
   word_type            base_ff [UNIT_DEPTH];
   word_type            base_in [UNIT_DEPTH];
   logic                big_ff [UNIT_DEPTH];
   logic                big_in [UNIT_DEPTH];
   logic                sat_ff [UNIT_DEPTH];
   logic                sat_in [UNIT_DEPTH];
   logic                nres_ff [UNIT_DEPTH];
   logic                nres_in [UNIT_DEPTH];
   logic [EXP_BITS-1:0] exp_ff [UNIT_DEPTH];
   logic [EXP_BITS-1:0] exp_in [UNIT_DEPTH];
   logic                fix_ff [UNIT_DEPTH];
   logic                fix_in [UNIT_DEPTH];
   rsp_type             fres_ff [UNIT_DEPTH];
   rsp_type             fres_in [UNIT_DEPTH];

   // stage 0: classify special cases, seed accumulator and base
   always_comb begin
      word_type ma;
      logic     nres;
      ma   = mag(a);
      nres = a[DATA_WIDTH-1] & b[0];
      acc_in[0]  = word_type'(1);
      base_in[0] = ma;
      big_in[0]  = 1'b0;
      nres_in[0] = nres;
      exp_in[0]  = b[EXP_BITS-1:0];
      sat_in[0]  = (b[DATA_WIDTH-1:EXP_BITS] != '0);
      fix_in[0]  = 1'b1;
      fres_in[0] = {word_type'(0), ST_OK};
      if (b == '0) begin
         fres_in[0] = {word_type'(1), ST_OK};
      end else if (b[DATA_WIDTH-1]) begin
         if (a == '0) begin
            fres_in[0] = {word_type'(0), ST_DOMAIN};
         end else if (ma == word_type'(1)) begin
            fres_in[0] = {(nres ? '1 : word_type'(1)), ST_OK};
         end
      end else if (ma == '0) begin
         fres_in[0] = {word_type'(0), ST_OK};
      end else if (ma == word_type'(1)) begin
         fres_in[0] = {(nres ? '1 : word_type'(1)), ST_OK};
      end else begin
         fix_in[0] = 1'b0;
      end
   end

   always_comb begin
      logic [2*DATA_WIDTH-1:0] prod;
      logic [2*DATA_WIDTH-1:0] lim;
      for (int k = 1; k < UNIT_DEPTH; k++) begin
         acc_in[k]  = acc_ff[k-1];
         base_in[k] = base_ff[k-1];
         big_in[k]  = big_ff[k-1];
         sat_in[k]  = sat_ff[k-1];
         nres_in[k] = nres_ff[k-1];
         exp_in[k]  = exp_ff[k-1];
         fix_in[k]  = fix_ff[k-1];
         fres_in[k] = fres_ff[k-1];
         lim  = nres_ff[k-1] ? LIM_POS : (LIM_POS - 1'b1);
         prod = '0;
         if (k <= POW_STEPS) begin
            if ((k % 2) == 1) begin
               // multiply step for exponent bit (k-1)/2
               prod = acc_ff[k-1] * base_ff[k-1];
               if (exp_ff[k-1][(k-1)/2]) begin
                  if (big_ff[k-1] || (prod > lim)) begin
                     sat_in[k] = 1'b1;
                  end else begin
                     acc_in[k] = prod[DATA_WIDTH-1:0];
                  end
               end
            end else begin
               prod = base_ff[k-1] * base_ff[k-1];
               if (prod > lim) begin
                  big_in[k] = 1'b1;
               end else begin
                  base_in[k] = prod[DATA_WIDTH-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      base_ff <= base_in;
      big_ff  <= big_in;
      sat_ff  <= sat_in;
      nres_ff <= nres_in;
      exp_ff  <= exp_in;
      fix_ff  <= fix_in;
      fres_ff <= fres_in;
   end

   always_comb begin
      word_type accv;
      accv = acc_ff[UNIT_DEPTH-1];
      if (fix_ff[UNIT_DEPTH-1]) begin
         res = fres_ff[UNIT_DEPTH-1];
      end else if (sat_ff[UNIT_DEPTH-1]) begin
         res = {(nres_ff[UNIT_DEPTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                       : {1'b0, {(DATA_WIDTH-1){1'b1}}}), ST_SAT};
      end else begin
         res = {(nres_ff[UNIT_DEPTH-1] ? (~accv + word_type'(1)) : accv), ST_OK};
      end
   end

endmodule

/* sv/integer_alu_div_sqrt_pow_top.sv */
// A request passes the s0 register, the UNIT_DEPTH unit stages and the response register to rsp_strobe.
// Throughput: one transaction per cycle; busy is always low, the receiver cannot stall.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset (synchronous, active high) clears the valid bits only; data needs no reset.
module integer_alu_div_sqrt_pow_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  iadsp_pkg::req_type req_item,
   output logic               rsp_strobe,
   output iadsp_pkg::rsp_type rsp_item
);
   import iadsp_pkg::*;

   logic     s0_valid_ff;
   req_type  s0_req_ff;
   word_type s0_arith_ff;
   word_type arith_in;

   logic [UNIT_DEPTH-1:0] vld_ff;
   logic [2:0]            mode_ff [UNIT_DEPTH];
   word_type              arith_ff [UNIT_DEPTH];

   rsp_type div_res;
   rsp_type sqrt_res;
   rsp_type pow_res;
   rsp_type rsp_in;
   logic    rsp_strobe_ff;
   rsp_type rsp_item_ff;

   assign busy = 1'b0;

   always_comb begin
      case (req_item.mode)
         MODE_ADD: arith_in = word_type'(req_item.operand_a) + word_type'(req_item.operand_b);
         MODE_SUB: arith_in = word_type'(req_item.operand_a) - word_type'(req_item.operand_b);
         MODE_MUL: arith_in = word_type'(req_item.operand_a) * word_type'(req_item.operand_b);
         default:  arith_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         vld_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
         vld_ff      <= {vld_ff[UNIT_DEPTH-2:0], s0_valid_ff};
         rsp_strobe_ff <= vld_ff[UNIT_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      s0_req_ff   <= req_item;
      s0_arith_ff <= arith_in;
      mode_ff[0]  <= s0_req_ff.mode;
      arith_ff[0] <= s0_arith_ff;
      for (int k = 1; k < UNIT_DEPTH; k++) begin
         mode_ff[k]  <= mode_ff[k-1];
         arith_ff[k] <= arith_ff[k-1];
      end
      rsp_item_ff <= rsp_in;
   end

   iadsp_div u_div (
      .clock (clock),
      .a     (word_type'(s0_req_ff.operand_a)),
      .b     (word_type'(s0_req_ff.operand_b)),
      .res   (div_res)
   );

   iadsp_sqrt u_sqrt (
      .clock (clock),
      .a     (word_type'(s0_req_ff.operand_a)),
      .res   (sqrt_res)
   );

   iadsp_pow u_pow (
      .clock (clock),
      .a     (word_type'(s0_req_ff.operand_a)),
      .b     (word_type'(s0_req_ff.operand_b)),
      .res   (pow_res)
   );

   always_comb begin
      case (mode_ff[UNIT_DEPTH-1])
         MODE_ADD:  rsp_in = {arith_ff[UNIT_DEPTH-1], ST_OK};
         MODE_SUB:  rsp_in = {arith_ff[UNIT_DEPTH-1], ST_OK};
         MODE_MUL:  rsp_in = {arith_ff[UNIT_DEPTH-1], ST_OK};
         MODE_DIV:  rsp_in = div_res;
         MODE_SQRT: rsp_in = sqrt_res;
         MODE_POW:  rsp_in = pow_res;
         default:   rsp_in = {word_type'(0), ST_DOMAIN};
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

/* sv/iadsp_checker.sv */
// Port-level checker for the integer ALU top level, attached by bind.
module iadsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input iadsp_pkg::req_type req_item,
   input logic               rsp_strobe,
   input iadsp_pkg::rsp_type rsp_item
);
   import iadsp_pkg::*;

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, LATENCY))
      else $error("result strobe without a transaction");

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("transaction lost");

   a_domain_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == ST_DOMAIN) |-> (rsp_item.result == '0))
      else $error("domain error with nonzero result");

   a_add_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_item.mode == MODE_ADD, LATENCY)) |->
      (word_type'(rsp_item.result) ==
       $past(word_type'(req_item.operand_a) + word_type'(req_item.operand_b), LATENCY)))
      else $error("add result mismatch");

endmodule

bind integer_alu_div_sqrt_pow_top iadsp_checker u_iadsp_checker (.*);

/* bench/tb_integer_alu_div_sqrt_pow_top.sv */
// Self-checking testbench for the integer ALU with divide, square root and power.
`timescale 1ns / 1ps

import iadsp_pkg::*;

class alu_scoreboard;
   rsp_type pending[$];
   int      errors;

   // exact integer square root, floor
   static function word_type isqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[DATA_WIDTH-1:0];
   endfunction

   static function rsp_type compute(req_type rq);
      rsp_type     r;
      word_type    a, b, ma, mb, q, lim;
      logic [63:0] m;
      logic        aneg, nres;
      a = rq.operand_a;
      b = rq.operand_b;
      ma = a[DATA_WIDTH-1] ? -a : a;
      mb = b[DATA_WIDTH-1] ? -b : b;
      aneg = a[DATA_WIDTH-1];
      r.result = '0;
      r.status = ST_OK;
      case (rq.mode)
         MODE_ADD: r.result = a + b;
         MODE_SUB: r.result = a - b;
         MODE_MUL: r.result = a * b;
         MODE_DIV: begin
            if (b == 0) r.status = ST_DOMAIN;
            else begin
               q = ma / mb;
               r.result = (aneg ^ b[DATA_WIDTH-1]) ? -q : q;
            end
         end
         MODE_SQRT: begin
            if (aneg) r.status = ST_DOMAIN;
            else r.result = isqrt({32'd0, a});
         end
         MODE_POW: begin
            nres = aneg && b[0];
            if (b == 0) r.result = 1;
            else if (b[DATA_WIDTH-1]) begin
               if (a == 0) r.status = ST_DOMAIN;
               else if (ma == 1) r.result = nres ? '1 : 1;
            end else if (ma != 0) begin
               lim = nres ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
               m = 1;
               if (ma != 1) begin
                  for (int unsigned i = 0; i < b; i++) begin
                     if (m > lim / ma) begin
                        r.result = lim;
                        r.status = ST_SAT;
                        break;
                     end
                     m = m * ma;
                  end
               end
               if (r.status == ST_OK) r.result = nres ? -m[DATA_WIDTH-1:0] : m[DATA_WIDTH-1:0];
            end
         end
         default: r.status = ST_DOMAIN;
      endcase
      return r;
   endfunction

   function void note_request(req_type rq);
      pending.push_back(compute(rq));
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected transaction: result %h status %0d", got.result, got.status);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.result !== want.result) begin
         $error("result: expected %h actual %h", want.result, got.result);
         errors++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d actual %0d", want.status, got.status);
         errors++;
      end
   endfunction
endclass

module tb_integer_alu_div_sqrt_pow_top;
   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   int      idle_pct;
   alu_scoreboard alu_sb;

   integer_alu_div_sqrt_pow_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && start && !busy) alu_sb.note_request(req_item);
      if (!reset && rsp_strobe) alu_sb.check_response(rsp_item);
   end

   function automatic word_type rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 16) - 8;
         1: return {1'b1, 31'd0} + $urandom_range(0, 3);
         2: return {1'b0, {31{1'b1}}} - $urandom_range(0, 3);
         3: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic [2:0] md, word_type a, word_type b);
      while ($urandom_range(1, 100) <= idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_item <= '{mode: md, operand_a: a, operand_b: b};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (alu_sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      logic [2:0] md;
      word_type   a, b;
      md = 3'($urandom_range(0, 7));
      if (md > MODE_POW && $urandom_range(0, 3) != 0) md = 3'($urandom_range(0, 5));
      a = rand_operand();
      b = rand_operand();
      if (md == MODE_POW) begin
         if ($urandom_range(0, 2) == 0) a = $urandom_range(0, 12) - 6;
         if ($urandom_range(0, 1) == 0) b = $urandom_range(0, 40) - 5;
      end
      send(md, a, b);
   endtask

   localparam word_type MAXV = {1'b0, {31{1'b1}}};
   localparam word_type MINV = {1'b1, 31'd0};

   initial begin
      alu_sb = new();
      idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(MODE_ADD, MAXV, 1);
      send(MODE_ADD, '1, '1);
      send(MODE_SUB, MINV, 1);
      send(MODE_MUL, MAXV, MAXV);
      send(MODE_MUL, MINV, '1);
      send(MODE_DIV, 7, 0);
      send(MODE_DIV, MINV, '1);
      send(MODE_DIV, -7, 2);
      send(MODE_DIV, MINV, MINV);
      send(MODE_SQRT, MAXV, 0);
      send(MODE_SQRT, '1, 5);
      send(MODE_SQRT, 0, 0);
      send(MODE_POW, 0, 0);
      send(MODE_POW, 0, -3);
      send(MODE_POW, 1, MINV);
      send(MODE_POW, -1, -3);
      send(MODE_POW, -1, -4);
      send(MODE_POW, 5, -1);
      send(MODE_POW, 2, 31);
      send(MODE_POW, -2, 31);
      send(MODE_POW, -2, 33);
      send(MODE_POW, MINV, MAXV);
      send(MODE_POW, 0, 9);
      send(3'd6, 1, 1);
      send(3'd7, MAXV, MINV);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 64 : (ph == 2) ? 28 : 0;
         for (int i = 0; i < 450; i++) begin
            // occasional long run with no gaps
            if (ph == 3 && i % 100 == 0) idle_pct = (idle_pct == 0) ? 64 : 0;
            send_random();
         end
         drain();
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (alu_sb.errors == 0 && alu_sb.pending.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
